@@ design/weight_vector_quantize_sparsify_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the weight encoder
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHT_VECTOR_QUANTIZE_SPARSIFY_ENCODER_DEFINES_SVH
`define WEIGHT_VECTOR_QUANTIZE_SPARSIFY_ENCODER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define WVQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WVQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/wvqse_pkg.sv @@
// ----------------------------------------------------------------------------
// wvqse_pkg
// Types and constants shared by the weight encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wvqse_pkg;

	typedef enum logic [1:0] {
		MODE_RAW    = 2'd0,
		MODE_QUANT  = 2'd1,
		MODE_SPARSE = 2'd2,
		MODE_SPQ    = 2'd3
	} mode_t;

	// threshold 0.001f and the offset added to the quantized byte
	localparam logic [30:0] KEEP_THRESH = 31'h3A83126F;
	localparam logic [7:0]  QOFFSET     = 8'd128;

	// one classified word handed from front to back
	typedef struct packed {
		logic [31:0] bits;
		logic [15:0] idx;
		logic [7:0]  qbyte;
		logic [1:0]  kind;     // 0 four float bytes, 1 one byte, 2 idx+float, 3 idx+byte
		logic        drop;
	} work_t;

endpackage
`default_nettype wire

@@ design/wvqse_front.sv @@
// ----------------------------------------------------------------------------
// wvqse_front
// Accepts weights, keeps the position counter, quantizes and classifies.
// Two stages: product register, then saturate/classify register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wvqse_front import wvqse_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  mode,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] weight_bits,
	input  wire logic        last_weight,
	output logic             wk_valid,
	input  wire logic        wk_ready,
	output work_t            wk
);

	logic [INDEX_BITS-1:0] idx_q;
	logic                  v_s1, v_s2;
	logic [31:0]           bits_s1;
	logic [15:0]           idx_s1;
	logic [1:0]            mode_s1;
	logic                  sign_s1, nan_s1, keep_s1;
	logic [8:0]            pexp_s1;   // biased exponent of product, extended
	logic [24:0]           pman_s1;   // product mantissa normalised to 1.x (bit 23)
	logic                  zero_s1;
	work_t                 wk_s2;
	logic                  adv1, adv2;

	logic [7:0]  e;
	logic [23:0] m;
	logic [31:0] prod;
	logic [24:0] mr;
	logic        rbit, sticky, lsb;
	logic [8:0]  ex;

	assign adv2     = !v_s2 || wk_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// multiply by 127 with round to nearest even of the significand
	always_comb begin
		e      = weight_bits[30:23];
		m      = {(e != 8'd0), weight_bits[22:0]};
		prod   = {8'd0, m} * 32'd127;  // up to 31 bits
		ex     = {1'b0, e} + ((e == 8'd0) ? 9'd1 : 9'd0);
		mr     = '0;
		rbit   = 1'b0;
		sticky = 1'b0;
		lsb    = 1'b0;
		if (prod[30]) begin
			mr     = {1'b0, prod[30:7]};
			rbit   = prod[6];
			sticky = |prod[5:0];
			ex     = ex + 9'd7;
		end else begin
			mr     = {1'b0, prod[29:6]};
			rbit   = prod[5];
			sticky = |prod[4:0];
			ex     = ex + 9'd6;
		end
		lsb = mr[0];
		if (rbit && (sticky || lsb))
			mr = mr + 25'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			idx_q <= '0;
		end else if (adv1) begin
			v_s1 <= in_valid;
			if (in_valid)
				idx_q <= last_weight ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			bits_s1 <= weight_bits;
			idx_s1  <= 16'(idx_q);
			mode_s1 <= mode;
			sign_s1 <= weight_bits[31];
			nan_s1  <= (e == 8'hFF) && (weight_bits[22:0] != 23'd0);
			zero_s1 <= (weight_bits[30:0] == 31'd0);
			keep_s1 <= (weight_bits[30:0] > KEEP_THRESH) &&
				!((e == 8'hFF) && (weight_bits[22:0] != 23'd0));
			pexp_s1 <= ex;
			pman_s1 <= mr;
		end
	end

	// truncate |p| to integer and saturate
	logic [8:0]  pe;
	logic [23:0] pm;
	logic [7:0]  mag;
	logic [7:0]  q;
	logic        big;
	always_comb begin
		// mantissa carry from rounding bumps exponent
		pm  = pman_s1[24] ? pman_s1[24:1] : pman_s1[23:0];
		pe  = pman_s1[24] ? pexp_s1 + 9'd1 : pexp_s1;
		big = 1'b0;
		mag = 8'd0;
		if (nan_s1 || zero_s1 || pe < 9'd127) begin
			mag = 8'd0;
		end else if (pe >= 9'd134) begin
			big = 1'b1;
		end else begin
			mag = 8'(pm >> (9'd150 - pe));
		end
		if (nan_s1)
			q = 8'd0;
		else if (!sign_s1)
			q = (big || mag >= 8'd127) ? 8'd127 : mag;
		else
			q = (big || mag >= 8'd128) ? 8'h80 : 8'(-mag);
		wk_s2.bits  = bits_s1;
		wk_s2.idx   = idx_s1;
		wk_s2.qbyte = q + QOFFSET;
		wk_s2.kind  = mode_s1;
		wk_s2.drop  = (mode_s1 == MODE_SPARSE || mode_s1 == MODE_SPQ) && !keep_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv2)
			v_s2 <= v_s1 && !wk_s2.drop;
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1)
			wk <= wk_s2;
	end

	assign wk_valid = v_s2;

endmodule
`default_nettype wire

@@ design/wvqse_fifo.sv @@
// ----------------------------------------------------------------------------
// wvqse_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wvqse_fifo import wvqse_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  work_t      din,
	output logic       out_valid,
	input  wire logic  out_ready,
	output work_t      dout
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	work_t           mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign in_ready  = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign dout      = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

endmodule
`default_nettype wire

@@ design/wvqse_back.sv @@
// ----------------------------------------------------------------------------
// wvqse_back
// Serialises one classified word into its bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wvqse_back import wvqse_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wk_valid,
	output logic            wk_ready,
	input  work_t           wk,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_item
);

	logic [2:0] pos_q;
	logic [2:0] nbytes;
	logic [7:0] b;
	logic       fire, lastb;

	always_comb begin
		case (wk.kind)
			MODE_QUANT:  nbytes = 3'd1;
			MODE_SPARSE: nbytes = 3'd6;
			MODE_SPQ:    nbytes = 3'd3;
			default:     nbytes = 3'd4;
		endcase
		b = 8'd0;
		case (wk.kind)
			MODE_QUANT: b = wk.qbyte;
			MODE_SPARSE: begin
				case (pos_q)
					3'd0:    b = wk.idx[7:0];
					3'd1:    b = wk.idx[15:8];
					3'd2:    b = wk.bits[7:0];
					3'd3:    b = wk.bits[15:8];
					3'd4:    b = wk.bits[23:16];
					default: b = wk.bits[31:24];
				endcase
			end
			MODE_SPQ: begin
				case (pos_q)
					3'd0:    b = wk.idx[7:0];
					3'd1:    b = wk.idx[15:8];
					default: b = wk.qbyte;
				endcase
			end
			default: begin
				case (pos_q)
					3'd0:    b = wk.bits[7:0];
					3'd1:    b = wk.bits[15:8];
					3'd2:    b = wk.bits[23:16];
					default: b = wk.bits[31:24];
				endcase
			end
		endcase
		lastb = (pos_q == nbytes - 3'd1);
	end

	assign fire     = wk_valid && (!out_valid || out_ready);
	assign wk_ready = fire && lastb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (!out_valid || out_ready)
				out_valid <= wk_valid;
			if (fire)
				pos_q <= lastb ? '0 : pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte     <= b;
			last_of_item <= lastb;
		end
	end

endmodule
`default_nettype wire

@@ design/weight_vector_quantize_sparsify_encoder.sv @@
// Weight vector quantize / sparsify encoder.
// Input channel: in_valid/in_ready with weight_bits (IEEE single) and
// last_weight. Output channel: out_valid/out_ready with out_byte and
// last_of_item, one stream byte per word. Config channel: cfg_valid/cfg_ready
// writes the 2-bit compression mode; write it only while idle.
// Bytes per weight: raw 4, quantize 1, sparse 6 or 0, combined 3 or 0.
// The first byte of a weight passes two front stages, the queue and the
// byte register before it is presented on out_byte.
// Throughput is set by the byte serialiser: one byte a cycle while
// out_ready is high, so a weight is done once its bytes (six at most) are
// out; the front takes a weight a cycle while the queue has room.
// Reset clears the position counter, the mode, the queue and all valids.
// A stalled receiver holds the current byte; the queue then fills and
// in_ready falls. Dropped weights still advance the position counter.
// ----------------------------------------------------------------------------
// weight_vector_quantize_sparsify_encoder
// Top level: mode register, front, queue and byte serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module weight_vector_quantize_sparsify_encoder import wvqse_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  compression_mode,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] weight_bits,
	input  wire logic        last_weight,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             last_of_item
);

	logic [1:0] mode_q;
	logic       f_valid, f_ready, b_valid, b_ready;
	work_t      f_wk, b_wk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_RAW;
		else if (cfg_valid)
			mode_q <= compression_mode;
	end

	wvqse_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.clk, .arst_n, .mode(mode_q),
		.in_valid, .in_ready, .weight_bits, .last_weight,
		.wk_valid(f_valid), .wk_ready(f_ready), .wk(f_wk)
	);

	wvqse_fifo #(.DEPTH(4)) u_fifo (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .din(f_wk),
		.out_valid(b_valid), .out_ready(b_ready), .dout(b_wk)
	);

	wvqse_back u_back (
		.clk, .arst_n,
		.wk_valid(b_valid), .wk_ready(b_ready), .wk(b_wk),
		.out_valid, .out_ready, .out_byte, .last_of_item
	);

endmodule
`default_nettype wire

@@ design/wvqse_checker.sv @@
// ----------------------------------------------------------------------------
// wvqse_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "weight_vector_quantize_sparsify_encoder_defines.svh"
module wvqse_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       last_of_item
);

	`WVQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_of_item), "output word changed while stalled")
	`WVQ_ASSERT_NEXT(a_no_out_after_reset, clk, arst_n, $rose(arst_n), !out_valid, "output valid straight out of reset")
	`WVQ_ASSERT_IMPL(a_ready_known, clk, arst_n, 1'b1, !$isunknown(in_ready), "in_ready unknown")

endmodule

bind weight_vector_quantize_sparsify_encoder wvqse_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .out_byte, .last_of_item
);
`default_nettype wire

@@ sim/weight_vector_quantize_sparsify_encoder_test.sv @@
// ----------------------------------------------------------------------------
// Weight encoder testbench
// Drives weights through all four compression modes with random gaps and
// receiver stalls, predicts the byte stream in a scoreboard and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module weight_vector_quantize_sparsify_encoder_test;
	import wvqse_pkg::*;

	class byte_stream_board;
		mode_t       mode;
		logic [15:0] position;
		logic [7:0]  byte_q[$];
		logic        tail_q[$];
		int          fails;

		function new();
			mode = MODE_RAW;
			position = '0;
			fails = 0;
		endfunction

		// truncate(w*127) rounded once to single, saturated, offset by 128
		function logic [7:0] quant_byte(logic [31:0] w);
			logic [7:0]  ex;
			longint      mag;
			longint      half;
			longint      rem;
			int          len;
			int          drop;
			int          scale;
			longint      ival;
			int          q;
			ex = w[30:23];
			if (ex == 8'hFF) begin
				if (w[22:0] != 0) return QOFFSET;
				q = w[31] ? -128 : 127;
				return 8'(q + 128);
			end
			mag = (ex == 0) ? longint'(w[22:0]) : longint'({1'b1, w[22:0]});
			mag = mag * 127;
			scale = ((ex == 0) ? 1 : int'(ex)) - 150;
			len = 0;
			for (int i = 0; i < 40; i++) if (mag >> i != 0) len = i + 1;
			drop = (len > 24) ? len - 24 : 0;
			if (drop > 0) begin
				half = longint'(1) << (drop - 1);
				rem = mag & ((longint'(1) << drop) - 1);
				mag = mag >> drop;
				if (rem > half || (rem == half && mag[0])) mag = mag + 1;
			end
			scale = scale + drop;
			if (mag == 0) ival = 0;
			else if (scale >= 8) ival = 1000;
			else if (scale >= 0) ival = mag << scale;
			else if (scale <= -40) ival = 0;
			else ival = mag >> (-scale);
			if (!w[31]) q = (ival >= 127) ? 127 : int'(ival);
			else q = (ival >= 128) ? -128 : -int'(ival);
			return 8'(q + 128);
		endfunction

		function void push(logic [7:0] b, logic t);
			byte_q = {byte_q, b};
			tail_q = {tail_q, t};
		endfunction

		function void note_weight(logic [31:0] w, logic last);
			logic keep;
			keep = (w[30:0] > KEEP_THRESH) && !(w[30:23] == 8'hFF && w[22:0] != 0);
			case (mode)
				MODE_QUANT: push(quant_byte(w), 1'b1);
				MODE_SPARSE: if (keep) begin
					push(position[7:0], 1'b0);
					push(position[15:8], 1'b0);
					for (int k = 0; k < 4; k++) push(w[8*k +: 8], k == 3);
				end
				MODE_SPQ: if (keep) begin
					push(position[7:0], 1'b0);
					push(position[15:8], 1'b0);
					push(quant_byte(w), 1'b1);
				end
				default: for (int k = 0; k < 4; k++) push(w[8*k +: 8], k == 3);
			endcase
			position = last ? '0 : position + 16'd1;
		endfunction

		function void check_byte(logic [7:0] b, logic t);
			logic [7:0] eb;
			logic       et;
			if (byte_q.size() == 0) begin
				$display("%0t: unexpected word byte=%h last=%b", $time, b, t);
				fails++;
				return;
			end
			eb = byte_q.pop_front();
			et = tail_q.pop_front();
			if (eb !== b) begin
				$display("%0t: out_byte expected %h actual %h", $time, eb, b);
				fails++;
			end
			if (et !== t) begin
				$display("%0t: last_of_item expected %b actual %b", $time, et, t);
				fails++;
			end
		endfunction

		function int pending();
			return byte_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  compression_mode;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] weight_bits;
	logic        last_weight;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        last_of_item;

	byte_stream_board board = new();
	bit  calm;
	int  idle_cycles;
	int  results_seen;
	bit  held;
	int  hold_left;

	weight_vector_quantize_sparsify_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.compression_mode(compression_mode),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.weight_bits(weight_bits),
		.last_weight(last_weight),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_item(last_of_item)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function logic [31:0] pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return $urandom;
		if (r < 30) begin
			case ($urandom_range(0, 5))
				0: return 32'h7F800000;
				1: return 32'hFF800000;
				2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
				3: return {$urandom_range(0, 1) == 1, KEEP_THRESH + 31'($urandom_range(0, 2)) - 31'd1};
				4: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
				default: return {$urandom_range(0, 1) == 1, 31'd0};
			endcase
		end
		return {$urandom_range(0, 1) == 1, 8'($urandom_range(112, 128)), 23'($urandom)};
	endfunction

	task automatic send_weight(logic [31:0] w, logic last);
		int g;
		in_valid <= 1'b1;
		weight_bits <= w;
		last_weight <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_weight(w, last);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_mode(mode_t m);
		cfg_valid <= 1'b1;
		compression_mode <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.mode = m;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_run(int n);
		for (int i = 0; i < n; i++) send_weight(pick_weight(), $urandom_range(0, 7) == 0);
	endtask

	// receiver: random stalls, one long hold-off once traffic is flowing
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_byte(out_byte, last_of_item);
			results_seen++;
		end
		if (!held && results_seen > 150) begin
			held = 1;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 70) ||
				(out_ready && $urandom_range(0, 99) < 50);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("weight_vector_quantize_sparsify_encoder verification failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] directed[12];
		directed = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
			32'h7FC00001, 32'hFFFFFFFF, 32'h3F800000, 32'hBF810204,
			32'h3A83126F, 32'hBA831270, 32'h00000001, 32'h3F7FFFFF};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		compression_mode = MODE_RAW;
		in_valid = 1'b0;
		weight_bits = '0;
		last_weight = 1'b0;
		out_ready = 1'b0;
		calm = 1'b0;
		idle_cycles = 0;
		results_seen = 0;
		held = 0;
		hold_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 12; i++) send_weight(directed[i], i == 5);
		drain();
		write_mode(MODE_SPQ);
		for (int i = 0; i < 12; i++) send_weight(directed[i], i == 9);
		drain();

		for (int p = 0; p < 7; p++) begin
			calm = (p == 2);
			write_mode(mode_t'(p == 0 ? MODE_SPARSE : p == 1 ? MODE_QUANT : $urandom_range(0, 3)));
			random_run(55);
			drain();
		end
		calm = 1'b0;

		write_mode(MODE_SPARSE);
		for (int i = 0; i < 12; i++) send_weight(32'h3F800000 ^ 32'($urandom_range(0, 255)), 1'b0);
		drain();
		write_mode(MODE_RAW);
		random_run(30);
		drain();

		if (board.fails == 0)
			$display("weight_vector_quantize_sparsify_encoder verification clean");
		else
			$display("weight_vector_quantize_sparsify_encoder verification failed");
		$finish;
	end

endmodule
